[design/hhbp_pkg.sv]
// Package for the HTTP header byte parser: phase codes, byte codes, queue entry type.
// Used by hhbp_front, hhbp_back and http_header_byte_parser.
`timescale 1ns / 1ps
package hhbp_pkg;
  localparam logic [4:0] P_FIRST = 5'd0;
  localparam logic [4:0] P_METHOD = 5'd1;
  localparam logic [4:0] P_BEF_RES = 5'd2;
  localparam logic [4:0] P_RES = 5'd3;
  localparam logic [4:0] P_BEF_RPROTO = 5'd4;
  localparam logic [4:0] P_RPROTO = 5'd5;
  localparam logic [4:0] P_SPROTO = 5'd6;
  localparam logic [4:0] P_BEF_STATUS = 5'd7;
  localparam logic [4:0] P_STATUS = 5'd8;
  localparam logic [4:0] P_REASON = 5'd9;
  localparam logic [4:0] P_FIRST_LF = 5'd10;
  localparam logic [4:0] P_LINE = 5'd11;
  localparam logic [4:0] P_NAME = 5'd12;
  localparam logic [4:0] P_BEF_COLON = 5'd13;
  localparam logic [4:0] P_BEF_VALUE = 5'd14;
  localparam logic [4:0] P_VALUE = 5'd15;
  localparam logic [4:0] P_BEF_CONT = 5'd16;
  localparam logic [4:0] P_CONT = 5'd17;
  localparam logic [4:0] P_HDR_LF = 5'd18;
  localparam logic [4:0] P_DONE = 5'd19;
  localparam logic [4:0] P_FAIL = 5'd20;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_SP = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_ONE = 8'd49;

  localparam logic [3:0] TAG_SKIP = 4'd0;
  localparam logic [3:0] TAG_METHOD = 4'd1;
  localparam logic [3:0] TAG_RES = 4'd2;
  localparam logic [3:0] TAG_PROTO = 4'd3;
  localparam logic [3:0] TAG_STATUS = 4'd4;
  localparam logic [3:0] TAG_REASON = 4'd5;
  localparam logic [3:0] TAG_NAME = 4'd6;
  localparam logic [3:0] TAG_VALUE = 4'd7;
  localparam logic [3:0] TAG_CONT = 4'd8;

  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam int QDEPTH = 2;

  // Classified byte passed from front to back
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
    logic       is_ws;
    logic       is_sp;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
    logic       is_digit;
  } item_t;

  function automatic logic [7:0] proto_char(input logic [2:0] idx);
    case (idx)
      3'd0: proto_char = 8'd72;
      3'd1: proto_char = 8'd84;
      3'd2: proto_char = 8'd84;
      3'd3: proto_char = 8'd80;
      3'd4: proto_char = 8'd47;
      3'd5: proto_char = 8'd49;
      3'd6: proto_char = 8'd46;
      default: proto_char = 8'd0;
    endcase
  endfunction
endpackage

[design/hhbp_front.sv]
// Front end: accepts input bytes, classifies them, queues them for the back end.
// Depends on hhbp_pkg.
`timescale 1ns / 1ps
module hhbp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [7:0]        in_data_byte,
  output logic              q_valid,
  output hhbp_pkg::item_t   q_item,
  input  logic              q_take
);
  hhbp_pkg::item_t mem_r [hhbp_pkg::QDEPTH];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  hhbp_pkg::item_t cls;
  logic push, pop;

  // Classify the byte
  always_comb begin
    cls.restart = in_kind;
    cls.data = in_data_byte;
    cls.is_sp = in_data_byte == hhbp_pkg::CH_SP;
    cls.is_cr = in_data_byte == hhbp_pkg::CH_CR;
    cls.is_lf = in_data_byte == hhbp_pkg::CH_LF;
    cls.is_colon = in_data_byte == hhbp_pkg::CH_COLON;
    cls.is_digit = in_data_byte inside {[8'd48:8'd57]};
    cls.is_ws = cls.is_sp || (in_data_byte inside {[8'd9:8'd13]});
  end

  assign in_stall = cnt_r == 2'(hhbp_pkg::QDEPTH);
  assign push = in_valid && !in_stall;
  assign pop = q_take;
  assign q_valid = cnt_r != 2'd0;
  assign q_item = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? !wp_r : wp_r;
    rp_nxt = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end
endmodule

[design/hhbp_back.sv]
// Back end: runs the parse state machine on queued bytes, holds the result register.
// Depends on hhbp_pkg.
`timescale 1ns / 1ps
module hhbp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              message_kind,
  input  logic              q_valid,
  input  hhbp_pkg::item_t   q_item,
  output logic              q_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_role_tag,
  output logic [1:0]        out_parse_status,
  output logic              out_header_line_done,
  output logic [1:0]        out_version,
  output logic [9:0]        out_status_code
);
  logic [4:0] phase_r, phase_nxt;
  logic [3:0] plen_r, plen_nxt;
  logic pok_r, pok_nxt;
  logic [7:0] pminor_r, pminor_nxt;
  logic [9:0] acc_r, acc_nxt;
  logic [1:0] digits_r, digits_nxt;
  logic sbad_r, sbad_nxt, name_r, name_nxt, vns_r, vns_nxt;
  logic [1:0] ver_r, ver_nxt;
  logic [9:0] code_r, code_nxt;
  logic ov_r;
  logic [3:0] tag_r;
  logic [1:0] st_r;
  logic ld_r;
  logic [3:0] tag;
  logic ld;
  logic [1:0] st, pchk;
  logic [4:0] ph;
  logic [13:0] acc10;
  hhbp_pkg::item_t it;

  assign q_take = q_valid && (!ov_r || !out_stall);
  assign it = q_item;
  assign acc10 = {acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {6'd0, it.data - hhbp_pkg::CH_ZERO};

  // Version check of the collected protocol text
  always_comb begin
    pchk = 2'd0;
    if (plen_r == 4'd8 && pok_r) begin
      if (pminor_r == hhbp_pkg::CH_ZERO) pchk = 2'd1;
      else if (pminor_r == hhbp_pkg::CH_ONE) pchk = 2'd2;
    end
  end

  // Parse one byte; re-dispatch chains are unrolled as entry phases
  always_comb begin
    phase_nxt = phase_r; plen_nxt = plen_r; pok_nxt = pok_r; pminor_nxt = pminor_r;
    acc_nxt = acc_r; digits_nxt = digits_r; sbad_nxt = sbad_r; name_nxt = name_r;
    vns_nxt = vns_r; ver_nxt = ver_r; code_nxt = code_r;
    tag = hhbp_pkg::TAG_SKIP; ld = 1'b0; ph = phase_r;
    if (ph == hhbp_pkg::P_FIRST) ph = message_kind ? hhbp_pkg::P_SPROTO : hhbp_pkg::P_METHOD;
    if (!it.is_sp) begin
      case (ph)
        hhbp_pkg::P_BEF_RES: ph = hhbp_pkg::P_RES;
        hhbp_pkg::P_BEF_RPROTO: ph = hhbp_pkg::P_RPROTO;
        hhbp_pkg::P_BEF_STATUS: ph = hhbp_pkg::P_STATUS;
        hhbp_pkg::P_BEF_VALUE: begin ph = hhbp_pkg::P_VALUE; vns_nxt = 1'b0; end
        hhbp_pkg::P_BEF_CONT: begin ph = hhbp_pkg::P_CONT; vns_nxt = 1'b0; end
        hhbp_pkg::P_LINE: if (!it.is_cr) begin ph = hhbp_pkg::P_NAME; name_nxt = 1'b0; end
        default: ;
      endcase
    end
    phase_nxt = ph;
    case (ph)
      hhbp_pkg::P_METHOD, hhbp_pkg::P_RES: begin
        if (!it.is_ws) tag = (ph == hhbp_pkg::P_METHOD) ? hhbp_pkg::TAG_METHOD : hhbp_pkg::TAG_RES;
        else if (it.is_sp)
          phase_nxt = (ph == hhbp_pkg::P_METHOD) ? hhbp_pkg::P_BEF_RES : hhbp_pkg::P_BEF_RPROTO;
        else phase_nxt = hhbp_pkg::P_FAIL;
      end
      hhbp_pkg::P_RPROTO, hhbp_pkg::P_SPROTO: begin
        if (!it.is_ws) begin
          tag = hhbp_pkg::TAG_PROTO;
          if (plen_r < 4'd7) begin
            if (it.data != hhbp_pkg::proto_char(plen_r[2:0])) pok_nxt = 1'b0;
          end else if (plen_r == 4'd7) pminor_nxt = it.data;
          if (plen_r != 4'd15) plen_nxt = plen_r + 4'd1;
        end else if ((ph == hhbp_pkg::P_RPROTO) ? it.is_cr : it.is_sp) begin
          ver_nxt = pchk;
          if (pchk == 2'd0) phase_nxt = hhbp_pkg::P_FAIL;
          else phase_nxt = (ph == hhbp_pkg::P_RPROTO) ? hhbp_pkg::P_FIRST_LF
                                                     : hhbp_pkg::P_BEF_STATUS;
        end else phase_nxt = hhbp_pkg::P_FAIL;
      end
      hhbp_pkg::P_STATUS: begin
        if (!it.is_ws) begin
          tag = hhbp_pkg::TAG_STATUS;
          if (!it.is_digit || digits_r == 2'd3 || (digits_r != 2'd0 && acc_r == 10'd0))
            sbad_nxt = 1'b1;
          else begin
            acc_nxt = acc10[9:0];
            digits_nxt = digits_r + 2'd1;
          end
        end else if (it.is_sp && !sbad_r) begin
          code_nxt = acc_r;
          phase_nxt = hhbp_pkg::P_REASON;
        end else phase_nxt = hhbp_pkg::P_FAIL;
      end
      hhbp_pkg::P_REASON: begin
        if (it.is_cr) phase_nxt = hhbp_pkg::P_FIRST_LF;
        else tag = hhbp_pkg::TAG_REASON;
      end
      hhbp_pkg::P_FIRST_LF: begin
        if (it.is_lf) begin phase_nxt = hhbp_pkg::P_LINE; name_nxt = 1'b0; end
        else phase_nxt = hhbp_pkg::P_FAIL;
      end
      hhbp_pkg::P_LINE: begin
        if (it.is_cr) begin
          name_nxt = 1'b0; vns_nxt = 1'b0; phase_nxt = hhbp_pkg::P_HDR_LF;
        end else phase_nxt = hhbp_pkg::P_BEF_CONT;
      end
      hhbp_pkg::P_NAME: begin
        if (it.is_colon) phase_nxt = hhbp_pkg::P_BEF_VALUE;
        else if (it.is_sp) phase_nxt = hhbp_pkg::P_BEF_COLON;
        else if (it.is_ws) phase_nxt = hhbp_pkg::P_FAIL;
        else begin tag = hhbp_pkg::TAG_NAME; name_nxt = 1'b1; end
      end
      hhbp_pkg::P_BEF_COLON: begin
        if (it.is_colon) phase_nxt = hhbp_pkg::P_BEF_VALUE;
        else if (!it.is_sp) phase_nxt = hhbp_pkg::P_FAIL;
      end
      hhbp_pkg::P_VALUE, hhbp_pkg::P_CONT: begin
        if (it.is_cr) begin ld = 1'b1; phase_nxt = hhbp_pkg::P_HDR_LF; end
        else begin
          tag = (ph == hhbp_pkg::P_VALUE) ? hhbp_pkg::TAG_VALUE : hhbp_pkg::TAG_CONT;
          if (!it.is_ws) vns_nxt = 1'b1;
        end
      end
      hhbp_pkg::P_HDR_LF: begin
        if (!it.is_lf) phase_nxt = hhbp_pkg::P_FAIL;
        else if (!name_r && !vns_r) phase_nxt = hhbp_pkg::P_DONE;
        else phase_nxt = hhbp_pkg::P_LINE;
      end
      hhbp_pkg::P_BEF_RES, hhbp_pkg::P_BEF_RPROTO, hhbp_pkg::P_BEF_STATUS,
      hhbp_pkg::P_BEF_VALUE, hhbp_pkg::P_BEF_CONT, hhbp_pkg::P_DONE: ;
      default: phase_nxt = hhbp_pkg::P_FAIL;
    endcase
    st = hhbp_pkg::ST_PENDING;
    if (phase_nxt == hhbp_pkg::P_DONE) st = hhbp_pkg::ST_DONE;
    else if (phase_nxt == hhbp_pkg::P_FAIL) begin
      st = hhbp_pkg::ST_ERROR; tag = hhbp_pkg::TAG_SKIP; ld = 1'b0;
    end
    // Restart clears everything and reports zeros
    if (it.restart) begin
      phase_nxt = hhbp_pkg::P_FIRST; plen_nxt = 4'd0; pok_nxt = 1'b1; pminor_nxt = 8'd0;
      acc_nxt = 10'd0; digits_nxt = 2'd0; sbad_nxt = 1'b0; name_nxt = 1'b0;
      vns_nxt = 1'b0; ver_nxt = 2'd0; code_nxt = 10'd0;
      tag = hhbp_pkg::TAG_SKIP; ld = 1'b0; st = hhbp_pkg::ST_PENDING;
    end
  end

  // Update parse state on each transfer from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hhbp_pkg::P_FIRST; plen_r <= 4'd0; pok_r <= 1'b1; pminor_r <= 8'd0;
      acc_r <= 10'd0; digits_r <= 2'd0; sbad_r <= 1'b0; name_r <= 1'b0; vns_r <= 1'b0;
      ver_r <= 2'd0; code_r <= 10'd0; ov_r <= 1'b0;
    end else begin
      if (q_take) begin
        phase_r <= phase_nxt; plen_r <= plen_nxt; pok_r <= pok_nxt; pminor_r <= pminor_nxt;
        acc_r <= acc_nxt; digits_r <= digits_nxt; sbad_r <= sbad_nxt; name_r <= name_nxt;
        vns_r <= vns_nxt; ver_r <= ver_nxt; code_r <= code_nxt;
      end
      if (q_take) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    if (q_take) begin
      tag_r <= tag; st_r <= st; ld_r <= ld;
    end
  end

  assign out_valid = ov_r;
  assign out_role_tag = tag_r;
  assign out_parse_status = st_r;
  assign out_header_line_done = ld_r;
  assign out_version = ver_r;
  assign out_status_code = code_r;
endmodule

[design/http_header_byte_parser.sv]
// Top level of the HTTP header byte parser: config register, front, back.
// Depends on hhbp_pkg, hhbp_front, hhbp_back.
`timescale 1ns / 1ps
// Usage:
//  Input channel in_valid/in_stall carries in_kind (1 = restart) and in_data_byte.
//  Output channel out_valid/out_stall gives one result per input byte: role tag,
//  parse status, header line done, version and status code.
//  A transfer happens at a clock edge with valid high and stall low.
//  From an input transfer to the earliest result transfer, the byte passes the
//  two-entry queue of the front end and then the back end result register.
//  Throughput is one byte per cycle while out_stall is low; the parse state machine updates on each byte taken.
//  When the receiver stalls, the result holds and the queue fills; in_stall rises
//  once both queue entries are occupied.
//  Register message_kind at byte address 0 (APB port): 0 request, 1 response.
//  Reset (rst_n low, synchronous) empties the queue, clears the parse state to
//  before the first line and message_kind to 0.
module http_header_byte_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_role_tag,
  output logic [1:0]  out_parse_status,
  output logic        out_header_line_done,
  output logic [1:0]  out_version,
  output logic [9:0]  out_status_code,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic kind_r;
  logic q_valid, q_take;
  hhbp_pkg::item_t q_item;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {31'd0, kind_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) kind_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      kind_r <= cfg_pwdata[0];
  end

  hhbp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_data_byte(in_data_byte),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  hhbp_back u_back (
    .clk(clk), .rst_n(rst_n), .message_kind(kind_r),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .out_valid(out_valid), .out_stall(out_stall), .out_role_tag(out_role_tag),
    .out_parse_status(out_parse_status), .out_header_line_done(out_header_line_done),
    .out_version(out_version), .out_status_code(out_status_code)
  );
endmodule

[design/hhbp_checker.sv]
// Port-level checker for the HTTP header byte parser, bound to the top level.
// Depends on http_header_byte_parser ports only.
`timescale 1ns / 1ps
module hhbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_role_tag,
  input logic [1:0] out_parse_status,
  input logic       out_header_line_done
);
  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_role_tag))
    else $error("stalled result changed");

  // Error results carry no role tag
  a_err_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_status == 2'd2 |-> out_role_tag == 4'd0 && !out_header_line_done)
    else $error("error result with tag");

  // Parse status never reads 3
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_parse_status != 2'd3)
    else $error("bad status code");

  // Line completion only on a skipped byte
  a_ld: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_line_done |-> out_role_tag == 4'd0 && out_parse_status == 2'd0)
    else $error("line done on tagged byte");
endmodule

bind http_header_byte_parser hhbp_checker u_hhbp_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_role_tag(out_role_tag), .out_parse_status(out_parse_status),
  .out_header_line_done(out_header_line_done)
);
